[sv/dgbs_pkg.sv]
package dgbs_pkg;

    // frame geometry and model widths
    localparam int PIXEL_COUNT = 524288;
    localparam int ADDR_W      = $clog2(PIXEL_COUNT);
    localparam int AGE_W       = 16;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // reciprocal 65536/age: 17 quotient bits, one bit per stage
    localparam int RECIP_W     = 17;
    localparam int REM_W       = AGE_W + 1;
    localparam int DIV_STAGES  = RECIP_W;

    // multiply and accumulate stages of the model update
    localparam int UPD_STAGES  = 5;

    // stages from RAM read to writeback (read, match, divider, update)
    localparam int LAT         = 2 + DIV_STAGES + UPD_STAGES;

    // register indexes of the configuration channel
    typedef enum logic [1:0] {
        CFG_MATCH_FACTOR = 2'd0,
        CFG_INIT_VAR     = 2'd1,
        CFG_FG_LIMIT     = 2'd2
    } cfg_idx_t;

    // which model the pixel updates
    typedef enum logic [1:0] {
        SEL_APP,
        SEL_CAND,
        SEL_NONE
    } sel_t;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic [7:0]       var_q;
        logic [7:0]       mean;
    } model_t;

    // one RAM word: candidate in the upper half
    typedef struct packed {
        model_t cand;
        model_t app;
    } rec_t;

    // what travels with an item from the match stage to writeback
    typedef struct packed {
        rec_t       rec;
        logic [7:0] pix;
        sel_t       sel;
        model_t     mdl;
    } pay_t;

endpackage

[sv/dgbs_ram.sv]
module dgbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/dgbs_recip.sv]
module dgbs_recip (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  logic                              in_valid,
    input  dgbs_pkg::pay_t                    in_pay,
    input  logic [dgbs_pkg::AGE_W-1:0]        in_den,
    output logic                              out_valid,
    output dgbs_pkg::pay_t                    out_pay,
    output logic [dgbs_pkg::RECIP_W-1:0]      out_recip
);

    localparam int N     = dgbs_pkg::DIV_STAGES;
    localparam int Q_W   = dgbs_pkg::RECIP_W;
    localparam int R_W   = dgbs_pkg::REM_W;
    localparam int D_W   = dgbs_pkg::AGE_W;

    logic           v_reg   [N];
    dgbs_pkg::pay_t pay_reg [N];
    logic [D_W-1:0] den_reg [N];
    logic [R_W-1:0] rem_reg [N];
    logic [Q_W-1:0] q_reg   [N];

    logic [R_W-1:0] rem_next [N];
    logic [Q_W-1:0] q_next   [N];

    // one restoring step per stage, dividend 2^16 enters at the first stage
    always_comb begin
        logic [R_W-1:0] src_rem;
        logic [Q_W-1:0] src_q;
        logic [D_W-1:0] src_den;
        logic [R_W-1:0] sh;
        logic           ge;
        for (int i = 0; i < N; i++) begin
            if (i == 0) begin
                src_rem = '0;
                src_q   = '0;
                src_den = in_den;
            end else begin
                src_rem = rem_reg[i-1];
                src_q   = q_reg[i-1];
                src_den = den_reg[i-1];
            end
            sh = {src_rem[R_W-2:0], (i == 0)};
            ge = (sh >= {1'b0, src_den});
            rem_next[i] = ge ? (sh - {1'b0, src_den}) : sh;
            q_next[i]   = {src_q[Q_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < N; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay_reg[0] <= in_pay;
            den_reg[0] <= in_den;
            for (int i = 1; i < N; i++) begin
                pay_reg[i] <= pay_reg[i-1];
                den_reg[i] <= den_reg[i-1];
            end
            for (int i = 0; i < N; i++) begin
                rem_reg[i] <= rem_next[i];
                q_reg[i]   <= q_next[i];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_pay   = pay_reg[N-1];
    assign out_recip = q_reg[N-1];

endmodule

[sv/dgbs_update.sv]
module dgbs_update (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  logic                              in_valid,
    input  dgbs_pkg::pay_t                    in_pay,
    input  logic [dgbs_pkg::RECIP_W-1:0]      in_recip,
    output logic                              out_valid,
    output dgbs_pkg::pay_t                    out_pay,
    output logic [7:0]                        out_mean,
    output logic [7:0]                        out_var
);

    localparam int A_W  = dgbs_pkg::RECIP_W;
    localparam int P_W  = A_W + 8;
    localparam int V_W  = 32;
    localparam int AV_W = A_W + V_W;
    localparam int S_W  = AV_W + 1;

    logic [dgbs_pkg::UPD_STAGES-1:0] v_reg;

    dgbs_pkg::pay_t   pay1_reg, pay2_reg, pay3_reg, pay4_reg, pay5_reg;
    logic [A_W-1:0]   a1_reg, a2_reg, a3_reg;
    logic [P_W-1:0]   km1_reg, ap1_reg, kv1_reg, kv2_reg, kv3_reg, kv4_reg;
    logic [P_W-1:0]   m16_2_reg, d2_reg;
    logic [7:0]       mean3_reg, mean4_reg, mean5_reg, var5_reg;
    logic [V_W-1:0]   v16_3_reg;
    logic [AV_W-1:0]  av4_reg;

    logic [A_W-1:0]   keep;
    logic [P_W-1:0]   m16_next, p16, d_next;
    logic [47:0]      dd;
    logic [S_W-1:0]   sum;

    // stage 1: weights and their products with mean, pixel and variance
    assign keep = A_W'(1 << 16) - in_recip;

    // stage 2: new mean in Q16 and its distance to the pixel
    assign m16_next = km1_reg + ap1_reg;
    assign p16      = P_W'({pay1_reg.pix, 16'h0000});
    assign d_next   = (m16_next > p16) ? (m16_next - p16) : (p16 - m16_next);

    // stage 3 squares the distance, stage 5 blends the variance
    assign dd  = 48'(d2_reg[23:0]) * 48'(d2_reg[23:0]);
    assign sum = S_W'({kv4_reg, 16'h0000}) + S_W'(av4_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[dgbs_pkg::UPD_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pay1_reg  <= in_pay;
            a1_reg    <= in_recip;
            km1_reg   <= P_W'(keep) * P_W'(in_pay.mdl.mean);
            ap1_reg   <= P_W'(in_recip) * P_W'(in_pay.pix);
            kv1_reg   <= P_W'(keep) * P_W'(in_pay.mdl.var_q);

            pay2_reg  <= pay1_reg;
            a2_reg    <= a1_reg;
            kv2_reg   <= kv1_reg;
            m16_2_reg <= m16_next;
            d2_reg    <= d_next;

            pay3_reg  <= pay2_reg;
            a3_reg    <= a2_reg;
            kv3_reg   <= kv2_reg;
            mean3_reg <= m16_2_reg[23:16];
            v16_3_reg <= dd[47:16];

            pay4_reg  <= pay3_reg;
            kv4_reg   <= kv3_reg;
            mean4_reg <= mean3_reg;
            av4_reg   <= AV_W'(a3_reg) * AV_W'(v16_3_reg);

            pay5_reg  <= pay4_reg;
            mean5_reg <= mean4_reg;
            var5_reg  <= (sum[S_W-1:32] > (S_W-32)'(255)) ? 8'hff : sum[39:32];
        end
    end

    assign out_valid = v_reg[dgbs_pkg::UPD_STAGES-1];
    assign out_pay   = pay5_reg;
    assign out_mean  = mean5_reg;
    assign out_var   = var5_reg;

endmodule

[sv/dual_gaussian_background_subtract_unit.sv]
// Channel   Dir  Handshake             Payload
// s_        in   s_tvalid / s_tready   s_tdata: pixel_index, pixel_value
// m_        out  m_tvalid / m_tready   m_tdata: foreground, background_mean
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel per cycle unless the output stalls or a pixel waits on its index; a result is offered
// once its pixel has passed the stages (RAM read at the transfer, match, 17 divider stages for
// 65536/age, 5 update stages, output).
// After reset a clearing pass writes all 524288 model words, one per cycle,
// and no pixel is taken until it ends.
// A pixel whose index is still in flight waits until its model is written back.
// The whole pipeline holds while the output register is full and not taken.
module dual_gaussian_background_subtract_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [18:0] pixel_index, [26:19] pixel_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] foreground, [8:1] background_mean
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int LAT = dgbs_pkg::LAT;
    localparam int AW  = dgbs_pkg::ADDR_W;
    localparam int GW  = dgbs_pkg::AGE_W;

    // configuration
    logic [11:0] match_factor_reg;
    logic [7:0]  init_var_reg;
    logic [15:0] fg_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_factor_reg <= 12'd144;
            init_var_reg     <= 8'd20;
            fg_limit_reg     <= 16'd60;
        end else if (cfg_valid) begin
            case (dgbs_pkg::cfg_idx_t'(cfg_index))
                dgbs_pkg::CFG_MATCH_FACTOR: match_factor_reg <= cfg_data[11:0];
                dgbs_pkg::CFG_INIT_VAR:     init_var_reg     <= cfg_data[7:0];
                dgbs_pkg::CFG_FG_LIMIT:     fg_limit_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // clearing pass
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(dgbs_pkg::PIXEL_COUNT - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // pipeline control
    logic          out_valid_reg;
    logic          adv;
    logic          hazard;
    logic          s_accept;
    logic [AW-1:0] in_idx;
    logic          tag_valid_reg [LAT];
    logic [AW-1:0] tag_idx_reg   [LAT];

    assign adv      = !out_valid_reg || m_tready;
    assign in_idx   = s_tdata[AW-1:0];
    assign s_tready = !clearing_reg && adv && !hazard;
    assign s_accept = s_tvalid && s_tready;

    // same pixel still in flight
    always_comb begin
        hazard = 1'b0;
        for (int i = 0; i < LAT; i++) begin
            if (tag_valid_reg[i] && (tag_idx_reg[i] == in_idx)) begin
                hazard = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                tag_valid_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            tag_valid_reg[0] <= s_accept;
            for (int i = 1; i < LAT; i++) begin
                tag_valid_reg[i] <= tag_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_idx_reg[0] <= in_idx;
            for (int i = 1; i < LAT; i++) begin
                tag_idx_reg[i] <= tag_idx_reg[i-1];
            end
        end
    end

    // model RAM
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    dgbs_pkg::rec_t  ram_wdata;
    dgbs_pkg::rec_t  ram_rdata;
    dgbs_pkg::rec_t  wb_rec;
    dgbs_pkg::rec_t  clr_rec;
    logic            wb_we;

    assign clr_rec.app  = '{age: GW'(1), var_q: 8'd0, mean: 8'd0};
    assign clr_rec.cand = '{age: GW'(1), var_q: 8'd0, mean: 8'd0};

    assign ram_we    = clearing_reg || wb_we;
    assign ram_waddr = clearing_reg ? clr_cnt_reg : tag_idx_reg[LAT-1];
    assign ram_wdata = clearing_reg ? clr_rec : wb_rec;

    dgbs_ram #(
        .WIDTH ($bits(dgbs_pkg::rec_t)),
        .DEPTH (dgbs_pkg::PIXEL_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    // read stage
    logic [7:0] r0_pix_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            r0_pix_reg <= s_tdata[AW+7:AW];
        end
    end

    // match stage
    logic [7:0]     da, dc;
    logic           match_app, match_cand;
    dgbs_pkg::pay_t r1_next;
    logic [GW-1:0]  den_next;
    dgbs_pkg::pay_t r1_pay_reg;
    logic [GW-1:0]  r1_den_reg;

    assign da = (r0_pix_reg > ram_rdata.app.mean) ? (r0_pix_reg - ram_rdata.app.mean)
                                                  : (ram_rdata.app.mean - r0_pix_reg);
    assign dc = (r0_pix_reg > ram_rdata.cand.mean) ? (r0_pix_reg - ram_rdata.cand.mean)
                                                   : (ram_rdata.cand.mean - r0_pix_reg);
    assign match_app  = ({4'h0, 16'(da) * 16'(da)} << 4)
                        < (20'(match_factor_reg) * 20'(ram_rdata.app.var_q));
    assign match_cand = ({4'h0, 16'(dc) * 16'(dc)} << 4)
                        < (20'(match_factor_reg) * 20'(ram_rdata.cand.var_q));

    always_comb begin
        r1_next.rec = ram_rdata;
        r1_next.pix = r0_pix_reg;
        if (match_app) begin
            r1_next.sel = dgbs_pkg::SEL_APP;
            r1_next.mdl = ram_rdata.app;
        end else if (match_cand) begin
            r1_next.sel = dgbs_pkg::SEL_CAND;
            r1_next.mdl = ram_rdata.cand;
        end else begin
            r1_next.sel = dgbs_pkg::SEL_NONE;
            r1_next.mdl = ram_rdata.cand;
        end
        // an age of zero weighs as one
        den_next = (r1_next.mdl.age == '0) ? GW'(1) : r1_next.mdl.age;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_pay_reg <= r1_next;
            r1_den_reg <= den_next;
        end
    end

    // reciprocal and update
    logic                          div_valid;
    dgbs_pkg::pay_t                div_pay;
    logic [dgbs_pkg::RECIP_W-1:0]  div_recip;
    logic                          upd_valid;
    dgbs_pkg::pay_t                upd_pay;
    logic [7:0]                    upd_mean, upd_var;

    dgbs_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (tag_valid_reg[1]),
        .in_pay    (r1_pay_reg),
        .in_den    (r1_den_reg),
        .out_valid (div_valid),
        .out_pay   (div_pay),
        .out_recip (div_recip)
    );

    dgbs_update u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (div_valid),
        .in_pay    (div_pay),
        .in_recip  (div_recip),
        .out_valid (upd_valid),
        .out_pay   (upd_pay),
        .out_mean  (upd_mean),
        .out_var   (upd_var)
    );

    // writeback: pick the updated model, swap, classify
    dgbs_pkg::model_t upd_mdl, fresh, app1, cand1;
    logic [7:0]       dfg;
    logic             fg_next;

    always_comb begin
        upd_mdl.mean  = upd_mean;
        upd_mdl.var_q = upd_var;
        upd_mdl.age   = (upd_pay.mdl.age < dgbs_pkg::AGE_MAX) ? (upd_pay.mdl.age + 1'b1)
                                                               : upd_pay.mdl.age;
        fresh.mean  = upd_pay.pix;
        fresh.var_q = init_var_reg;
        fresh.age   = GW'(1);
        case (upd_pay.sel)
            dgbs_pkg::SEL_APP: begin
                app1  = upd_mdl;
                cand1 = upd_pay.rec.cand;
            end
            dgbs_pkg::SEL_CAND: begin
                app1  = upd_pay.rec.app;
                cand1 = upd_mdl;
            end
            default: begin
                app1  = upd_pay.rec.app;
                cand1 = fresh;
            end
        endcase
        if (cand1.age > app1.age) begin
            wb_rec.app  = cand1;
            wb_rec.cand = fresh;
        end else begin
            wb_rec.app  = app1;
            wb_rec.cand = cand1;
        end
        dfg = (wb_rec.app.mean > upd_pay.pix) ? (wb_rec.app.mean - upd_pay.pix)
                                              : (upd_pay.pix - wb_rec.app.mean);
        fg_next = (16'(dfg) * 16'(dfg)) > fg_limit_reg;
    end

    assign wb_we = adv && tag_valid_reg[LAT-1];

    // output register
    logic       out_fg_reg;
    logic [7:0] out_mean_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= tag_valid_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_fg_reg   <= fg_next;
            out_mean_reg <= wb_rec.app.mean;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'h00, out_mean_reg, out_fg_reg};

`ifndef SYNTH
    a_valid_align: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_valid == tag_valid_reg[LAT-1])
        else $error("update valid out of step with index line");
    a_no_input_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !tag_valid_reg[0] && !tag_valid_reg[LAT-1])
        else $error("item in flight during clearing pass");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(tag_idx_reg[LAT-1]) && $stable(tag_valid_reg[LAT-1]))
        else $error("writeback stage moved during stall");
    a_wb_once: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_we |=> (tag_idx_reg[LAT-1] != $past(tag_idx_reg[LAT-1]))
                  || !tag_valid_reg[LAT-1])
        else $error("same pixel written back twice in a row");
`endif

endmodule
